@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Property checked at every edge, reset included.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

@@ hdl/fpvr_pkg.sv @@
// Shared constants, types and the CORDIC angle table for the flight path rotation block.
package fpvr_pkg;

  localparam int ANGLE_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int VM_W        = 7;
  localparam int VM_PITCH    = 0;
  localparam int VM_ROLL     = 1;
  localparam int VM_TRK_VERT = 2;
  localparam int VM_HDG_MAG  = 3;
  localparam int VM_HDG_TRUE = 4;
  localparam int VM_TRK_MAG  = 5;
  localparam int VM_TRK_TRUE = 6;

  // Inverse CORDIC gain in Q24, plus a sign bit.
  localparam int GAIN_W = 25;
  localparam logic signed [GAIN_W-1:0] GAIN_Q24 = 25'sd10188014;

  // Extra bits of the x/y datapath over the angle width.
  localparam int GUARD_BITS = GAIN_W + 1;

  // Turn fraction and signed residual.
  localparam int Z_W = 32;
  localparam int R_W = 33;
  localparam logic [Z_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [Z_W-1:0] HALF_TURN    = 32'h8000_0000;

  // Rounding point of the finished result.
  localparam int FRAC_BITS = 24;

  typedef struct packed {
    logic ok;
    logic wanted;
    logic ground;
  } tag_t;

  // round(atan(2^-i) * 2^32 / (2*pi))
  function automatic logic [Z_W-1:0] atan_turn(input int idx);
    logic [Z_W-1:0] v;
    case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      24: v = 32'h00000029;
      25: v = 32'h00000014;
      26: v = 32'h0000000A;
      27: v = 32'h00000005;
      28: v = 32'h00000003;
      29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/fpvr_if.sv @@
// Valid/ready channel interfaces for sample input and marker output.
interface fpvr_in_if #(
  parameter int ANGLE_BITS = fpvr_pkg::ANGLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_BITS-1:0]  pitch_angle;
  logic signed [ANGLE_BITS-1:0]  roll_angle;
  logic signed [ANGLE_BITS-1:0]  track_vertical_angle;
  logic signed [ANGLE_BITS-1:0]  heading_magnetic;
  logic signed [ANGLE_BITS-1:0]  heading_true;
  logic signed [ANGLE_BITS-1:0]  track_magnetic;
  logic signed [ANGLE_BITS-1:0]  track_true;
  logic [fpvr_pkg::VM_W-1:0]     valid_mask;
  logic                          marker_wanted;
  logic                          on_ground;

  modport source (
    output valid, pitch_angle, roll_angle, track_vertical_angle, heading_magnetic,
           heading_true, track_magnetic, track_true, valid_mask, marker_wanted, on_ground,
    input  ready
  );
  modport sink (
    input  valid, pitch_angle, roll_angle, track_vertical_angle, heading_magnetic,
           heading_true, track_magnetic, track_true, valid_mask, marker_wanted, on_ground,
    output ready
  );
endinterface

interface fpvr_out_if #(
  parameter int ANGLE_BITS = fpvr_pkg::ANGLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [ANGLE_BITS:0]  fpv_alpha;
  logic signed [ANGLE_BITS:0]  fpv_beta;
  logic                        fpv_failure;
  logic                        fpv_shown;

  modport source (output valid, fpv_alpha, fpv_beta, fpv_failure, fpv_shown, input ready);
  modport sink   (input valid, fpv_alpha, fpv_beta, fpv_failure, fpv_shown, output ready);
endinterface

@@ hdl/flight_path_vector_rotation.sv @@
// Top level: flight path marker placement by roll rotation of the path deltas.
//
// Input channel in_ch carries one attitude/track sample per transfer; output
// channel out_ch returns exactly one marker result per sample, in order.
// The sample goes through two input stages (select and fold, gain multiply),
// then a chain of CORDIC_STEPS rotation cells (16 by default), then the
// rounding/saturating output register. The chain advances every cycle in
// which the output is not stalled, so a new sample can be taken each cycle
// while no untaken result is held.
// When a sample lacks a needed operand, alpha and beta repeat the last
// computed values, fpv_shown is 0 and fpv_failure follows marker_wanted.
// Reset empties the chain and clears the held alpha and beta to zero.
// While the output holds an untaken result, the whole chain stalls and
// in_ch.ready stays low; nothing is lost or duplicated.
module flight_path_vector_rotation #(
  parameter int ANGLE_BITS   = fpvr_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STEPS = fpvr_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fpvr_in_if.sink    in_ch,
  fpvr_out_if.source out_ch
);

  localparam int XW = ANGLE_BITS + fpvr_pkg::GUARD_BITS;
  localparam int SW = XW - fpvr_pkg::FRAC_BITS;
  localparam logic [63:0] OUT_LIMIT = (64'd46341 << ANGLE_BITS) >> 16;
  localparam logic signed [SW-1:0] LIM_P = OUT_LIMIT[SW-1:0];
  localparam logic signed [SW-1:0] LIM_N = -LIM_P;
  localparam logic signed [XW-1:0] HALF_LSB = XW'(64'd1 << (fpvr_pkg::FRAC_BITS - 1));

  logic                             adv;
  logic                             cv [CORDIC_STEPS+1];
  logic signed [XW-1:0]             cx [CORDIC_STEPS+1];
  logic signed [XW-1:0]             cy [CORDIC_STEPS+1];
  logic signed [fpvr_pkg::R_W-1:0]  cr [CORDIC_STEPS+1];
  fpvr_pkg::tag_t                   ct [CORDIC_STEPS+1];

  logic signed [XW-1:0]             rx;
  logic signed [XW-1:0]             ry;
  logic signed [SW-1:0]             sx;
  logic signed [SW-1:0]             sy;
  logic signed [ANGLE_BITS:0]       fa;
  logic signed [ANGLE_BITS:0]       fb;
  fpvr_pkg::tag_t                   last_tag;

  assign adv         = ~out_ch.valid | out_ch.ready;
  assign in_ch.ready = adv;

  fpvr_front #(.ANGLE_BITS(ANGLE_BITS), .XW(XW)) u_front (
    .clk                  (clk),
    .rst                  (rst),
    .adv                  (adv),
    .load                 (in_ch.valid),
    .pitch_angle          (in_ch.pitch_angle),
    .roll_angle           (in_ch.roll_angle),
    .track_vertical_angle (in_ch.track_vertical_angle),
    .heading_magnetic     (in_ch.heading_magnetic),
    .heading_true         (in_ch.heading_true),
    .track_magnetic       (in_ch.track_magnetic),
    .track_true           (in_ch.track_true),
    .valid_mask           (in_ch.valid_mask),
    .marker_wanted        (in_ch.marker_wanted),
    .on_ground            (in_ch.on_ground),
    .b_valid              (cv[0]),
    .b_x                  (cx[0]),
    .b_y                  (cy[0]),
    .b_r                  (cr[0]),
    .b_tag                (ct[0])
  );

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    fpvr_cell #(.XW(XW), .SHIFT(i), .ATAN(fpvr_pkg::atan_turn(i))) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (cv[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_r      (cr[i]),
      .in_tag    (ct[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_r     (cr[i+1]),
      .out_tag   (ct[i+1])
    );
  end

  // Round to nearest (half up), then saturate.
  always_comb begin
    last_tag = ct[CORDIC_STEPS];
    rx = cx[CORDIC_STEPS] + HALF_LSB;
    ry = cy[CORDIC_STEPS] + HALF_LSB;
    sx = rx[XW-1:fpvr_pkg::FRAC_BITS];
    sy = ry[XW-1:fpvr_pkg::FRAC_BITS];
    if (sx > LIM_P)      fb = LIM_P[ANGLE_BITS:0];
    else if (sx < LIM_N) fb = LIM_N[ANGLE_BITS:0];
    else                 fb = sx[ANGLE_BITS:0];
    if (sy > LIM_P)      fa = LIM_P[ANGLE_BITS:0];
    else if (sy < LIM_N) fa = LIM_N[ANGLE_BITS:0];
    else                 fa = sy[ANGLE_BITS:0];
  end

  // Output register doubles as the held alpha/beta.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid     <= 1'b0;
      out_ch.fpv_alpha <= '0;
      out_ch.fpv_beta  <= '0;
    end else if (adv) begin
      out_ch.valid <= cv[CORDIC_STEPS];
      if (cv[CORDIC_STEPS]) begin
        if (last_tag.ok) begin
          out_ch.fpv_alpha   <= fa;
          out_ch.fpv_beta    <= fb;
          out_ch.fpv_failure <= 1'b0;
          out_ch.fpv_shown   <= last_tag.wanted & ~last_tag.ground;
        end else begin
          out_ch.fpv_failure <= last_tag.wanted;
          out_ch.fpv_shown   <= 1'b0;
        end
      end
    end
  end

endmodule

@@ hdl/fpvr_front.sv @@
// Input stages: pair select, angle differences, quadrant fold, gain multiply.
module fpvr_front #(
  parameter int ANGLE_BITS = fpvr_pkg::ANGLE_BITS_DEF,
  parameter int XW         = ANGLE_BITS + fpvr_pkg::GUARD_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 load,
  input  logic signed [ANGLE_BITS-1:0]         pitch_angle,
  input  logic signed [ANGLE_BITS-1:0]         roll_angle,
  input  logic signed [ANGLE_BITS-1:0]         track_vertical_angle,
  input  logic signed [ANGLE_BITS-1:0]         heading_magnetic,
  input  logic signed [ANGLE_BITS-1:0]         heading_true,
  input  logic signed [ANGLE_BITS-1:0]         track_magnetic,
  input  logic signed [ANGLE_BITS-1:0]         track_true,
  input  logic [fpvr_pkg::VM_W-1:0]            valid_mask,
  input  logic                                 marker_wanted,
  input  logic                                 on_ground,
  output logic                                 b_valid,
  output logic signed [XW-1:0]                 b_x,
  output logic signed [XW-1:0]                 b_y,
  output logic signed [fpvr_pkg::R_W-1:0]      b_r,
  output fpvr_pkg::tag_t                       b_tag
);

  logic                             mag_ok;
  logic                             tru_ok;
  logic signed [ANGLE_BITS-1:0]     hdg;
  logic signed [ANGLE_BITS-1:0]     trk;
  logic signed [ANGLE_BITS-1:0]     hdiff;
  logic signed [ANGLE_BITS-1:0]     vdiff;
  logic signed [ANGLE_BITS:0]       hext;
  logic signed [ANGLE_BITS:0]       vext;
  logic [fpvr_pkg::Z_W-1:0]         z;
  logic [fpvr_pkg::Z_W-1:0]         zq;
  logic [fpvr_pkg::Z_W-1:0]         zf;
  logic                             flip;
  fpvr_pkg::tag_t                   tag_next;

  logic                             a_valid;
  logic signed [ANGLE_BITS:0]       a_h;
  logic signed [ANGLE_BITS:0]       a_v;
  logic signed [fpvr_pkg::R_W-1:0]  a_r;
  fpvr_pkg::tag_t                   a_tag;

  always_comb begin
    mag_ok = valid_mask[fpvr_pkg::VM_HDG_MAG] & valid_mask[fpvr_pkg::VM_TRK_MAG];
    tru_ok = valid_mask[fpvr_pkg::VM_HDG_TRUE] & valid_mask[fpvr_pkg::VM_TRK_TRUE];
    hdg    = mag_ok ? heading_magnetic : heading_true;
    trk    = mag_ok ? track_magnetic : track_true;
    hdiff  = hdg - trk;
    vdiff  = pitch_angle - track_vertical_angle;
    hext   = {hdiff[ANGLE_BITS-1], hdiff};
    vext   = {vdiff[ANGLE_BITS-1], vdiff};
    z      = fpvr_pkg::Z_W'(unsigned'(roll_angle)) << (fpvr_pkg::Z_W - ANGLE_BITS);
    zq     = z + fpvr_pkg::QUARTER_TURN;
    flip   = zq[fpvr_pkg::Z_W-1];
    zf     = flip ? z + fpvr_pkg::HALF_TURN : z;
    tag_next.ok     = (mag_ok | tru_ok) & valid_mask[fpvr_pkg::VM_PITCH]
                    & valid_mask[fpvr_pkg::VM_ROLL] & valid_mask[fpvr_pkg::VM_TRK_VERT];
    tag_next.wanted = marker_wanted;
    tag_next.ground = on_ground;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= load;
      a_h     <= flip ? -hext : hext;
      a_v     <= flip ? -vext : vext;
      a_r     <= {zf[fpvr_pkg::Z_W-1], zf};
      a_tag   <= tag_next;
      b_valid <= a_valid;
      b_x     <= XW'(a_h) * XW'(fpvr_pkg::GAIN_Q24);
      b_y     <= XW'(a_v) * XW'(fpvr_pkg::GAIN_Q24);
      b_r     <= a_r;
      b_tag   <= a_tag;
    end
  end

endmodule

@@ hdl/fpvr_cell.sv @@
// One CORDIC rotation cell of the chain.
module fpvr_cell #(
  parameter int                        XW    = fpvr_pkg::ANGLE_BITS_DEF + fpvr_pkg::GUARD_BITS,
  parameter int                        SHIFT = 0,
  parameter logic [fpvr_pkg::Z_W-1:0]  ATAN  = fpvr_pkg::atan_turn(0)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic signed [XW-1:0]             in_x,
  input  logic signed [XW-1:0]             in_y,
  input  logic signed [fpvr_pkg::R_W-1:0]  in_r,
  input  fpvr_pkg::tag_t                   in_tag,
  output logic                             out_valid,
  output logic signed [XW-1:0]             out_x,
  output logic signed [XW-1:0]             out_y,
  output logic signed [fpvr_pkg::R_W-1:0]  out_r,
  output fpvr_pkg::tag_t                   out_tag
);

  localparam logic signed [fpvr_pkg::R_W-1:0] ANG = {1'b0, ATAN};

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic                 pos;

  always_comb begin
    dx  = in_y >>> SHIFT;
    dy  = in_x >>> SHIFT;
    pos = ~in_r[fpvr_pkg::R_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
      out_x     <= pos ? in_x - dx : in_x + dx;
      out_y     <= pos ? in_y + dy : in_y - dy;
      out_r     <= pos ? in_r - ANG : in_r + ANG;
      out_tag   <= in_tag;
    end
  end

endmodule

@@ hdl/fpvr_check.sv @@
// Port-level checker for the flight path rotation block, with its bind.
`include "assert_macros.svh"

module fpvr_check #(
  parameter int ANGLE_BITS = fpvr_pkg::ANGLE_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [ANGLE_BITS:0] fpv_alpha,
  input logic signed [ANGLE_BITS:0] fpv_beta,
  input logic                       fpv_failure,
  input logic                       fpv_shown
);

  localparam logic [63:0] OUT_LIMIT = (64'd46341 << ANGLE_BITS) >> 16;
  localparam logic signed [ANGLE_BITS+1:0] LIM_P = OUT_LIMIT[ANGLE_BITS+1:0];
  localparam logic signed [ANGLE_BITS+1:0] LIM_N = -LIM_P;

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fpv_alpha) && $stable(fpv_beta) && $stable(fpv_failure) && $stable(fpv_shown))
  `ASSERT_IMPL(a_flags_excl, out_valid, !(fpv_failure && fpv_shown))
  `ASSERT_IMPL(a_stall_only, !in_ready, out_valid && !out_ready)
  `ASSERT_IMPL(a_range, out_valid, fpv_alpha <= LIM_P && fpv_alpha >= LIM_N && fpv_beta <= LIM_P && fpv_beta >= LIM_N)
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)

endmodule

bind flight_path_vector_rotation fpvr_check #(.ANGLE_BITS(ANGLE_BITS)) u_fpvr_check (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .fpv_alpha   (out_ch.fpv_alpha),
  .fpv_beta    (out_ch.fpv_beta),
  .fpv_failure (out_ch.fpv_failure),
  .fpv_shown   (out_ch.fpv_shown)
);

@@ test/tb_flight_path_vector_rotation.sv @@
// Testbench for flight_path_vector_rotation: directed and random samples checked against a predictor.
`timescale 1ns / 100ps

module tb_flight_path_vector_rotation;

  localparam int AB = fpvr_pkg::ANGLE_BITS_DEF;
  localparam int STEPS = fpvr_pkg::CORDIC_STEPS_DEF;
  localparam int MW = fpvr_pkg::VM_W;
  localparam int PIPE_LATENCY = STEPS + 3;
  localparam longint GAIN_INV = 10188014;
  localparam longint MARKER_LIMIT = 46341;
  localparam int RANDOM_ITEMS = 1825;

  localparam logic [MW-1:0] M_CORE = MW'((1 << fpvr_pkg::VM_PITCH) | (1 << fpvr_pkg::VM_ROLL)
                                         | (1 << fpvr_pkg::VM_TRK_VERT));
  localparam logic [MW-1:0] M_MAG = MW'((1 << fpvr_pkg::VM_HDG_MAG)
                                        | (1 << fpvr_pkg::VM_TRK_MAG));
  localparam logic [MW-1:0] M_TRUE = MW'((1 << fpvr_pkg::VM_HDG_TRUE)
                                         | (1 << fpvr_pkg::VM_TRK_TRUE));
  localparam logic [MW-1:0] M_ALL = M_CORE | M_MAG | M_TRUE;

  typedef struct packed {
    logic signed [AB-1:0] pitch;
    logic signed [AB-1:0] roll;
    logic signed [AB-1:0] tvert;
    logic signed [AB-1:0] hdg_mag;
    logic signed [AB-1:0] hdg_true;
    logic signed [AB-1:0] trk_mag;
    logic signed [AB-1:0] trk_true;
    logic [MW-1:0] mask;
    logic wanted;
    logic ground;
  } sample_t;

  typedef struct packed {
    logic signed [AB:0] alpha;
    logic signed [AB:0] beta;
    logic failure;
    logic shown;
  } marker_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpvr_in_if in_ch ();
  fpvr_out_if out_ch ();

  flight_path_vector_rotation dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // atan(2^-i) as a fraction of a full turn, 32-bit
  longint atan_step [0:STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  longint last_alpha = 0;
  longint last_beta = 0;
  marker_t marker_q[$];
  int n_sent = 0;
  int n_computed = 0;
  int n_checked = 0;
  int n_errors = 0;
  int burst_left = 0;
  int stall_run = 0;

  function automatic longint round_saturate(longint v);
    longint r;
    r = (v + (longint'(1) << 23)) >>> 24;
    if (r > MARKER_LIMIT) r = MARKER_LIMIT;
    if (r < -MARKER_LIMIT) r = -MARKER_LIMIT;
    return r;
  endfunction

  function automatic marker_t predict_marker(sample_t s);
    marker_t e;
    logic have_pair;
    logic signed [AB-1:0] hd;
    logic signed [AB-1:0] vd;
    logic [31:0] z;
    logic [31:0] zq;
    longint x, y, r, dx, dy;
    have_pair = 1'b1;
    hd = '0;
    if (s.mask[fpvr_pkg::VM_HDG_MAG] && s.mask[fpvr_pkg::VM_TRK_MAG])
      hd = s.hdg_mag - s.trk_mag;
    else if (s.mask[fpvr_pkg::VM_HDG_TRUE] && s.mask[fpvr_pkg::VM_TRK_TRUE])
      hd = s.hdg_true - s.trk_true;
    else
      have_pair = 1'b0;
    vd = s.pitch - s.tvert;
    if (have_pair && (s.mask & M_CORE) == M_CORE) begin
      z = {s.roll, {(32-AB){1'b0}}};
      x = longint'(hd) * GAIN_INV;
      y = longint'(vd) * GAIN_INV;
      zq = z + 32'h4000_0000;
      if (zq[31]) begin
        x = -x;
        y = -y;
        z = z + 32'h8000_0000;
      end
      r = longint'(int'(z));
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (r >= 0) begin
          x = x - dx;
          y = y + dy;
          r = r - atan_step[i];
        end else begin
          x = x + dx;
          y = y - dy;
          r = r + atan_step[i];
        end
      end
      last_beta = round_saturate(x);
      last_alpha = round_saturate(y);
      e.failure = 1'b0;
      e.shown = s.wanted;
      n_computed++;
    end else begin
      e.failure = s.wanted;
      e.shown = 1'b0;
    end
    if (s.ground) e.shown = 1'b0;
    e.alpha = last_alpha[AB:0];
    e.beta = last_beta[AB:0];
    return e;
  endfunction

  function automatic sample_t mk(int p, int r, int tv, int hm, int ht, int tm, int tt,
                                 logic [MW-1:0] mask, logic wanted, logic ground);
    sample_t s;
    s.pitch = p[AB-1:0];
    s.roll = r[AB-1:0];
    s.tvert = tv[AB-1:0];
    s.hdg_mag = hm[AB-1:0];
    s.hdg_true = ht[AB-1:0];
    s.trk_mag = tm[AB-1:0];
    s.trk_true = tt[AB-1:0];
    s.mask = mask;
    s.wanted = wanted;
    s.ground = ground;
    return s;
  endfunction

  // bias toward wrap points and small deltas
  function automatic int pick_angle();
    int v;
    case ($urandom_range(0, 7))
      0: v = $urandom_range(0, 1) ? 32767 : -32768;
      1: v = int'($urandom_range(0, 64)) - 32;
      default: v = int'($urandom);
    endcase
    return v;
  endfunction

  function automatic sample_t random_sample();
    logic [MW-1:0] mask;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: mask = M_ALL;
      5: mask = M_CORE | M_MAG;
      6: mask = M_CORE | M_TRUE;
      default: mask = MW'($urandom_range(0, 127));
    endcase
    return mk(pick_angle(), int'($urandom), pick_angle(), pick_angle(), pick_angle(),
              pick_angle(), pick_angle(), mask, $urandom_range(0, 3) != 0,
              $urandom_range(0, 4) == 0);
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(sample_t s);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.pitch_angle = s.pitch;
    in_ch.roll_angle = s.roll;
    in_ch.track_vertical_angle = s.tvert;
    in_ch.heading_magnetic = s.hdg_mag;
    in_ch.heading_true = s.hdg_true;
    in_ch.track_magnetic = s.trk_mag;
    in_ch.track_true = s.trk_true;
    in_ch.valid_mask = s.mask;
    in_ch.marker_wanted = s.wanted;
    in_ch.on_ground = s.ground;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    marker_q.push_back(predict_marker(s));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic test_reset_hold();
    send_sample(mk(100, 0, 0, 0, 0, 0, 0, M_CORE, 1'b1, 1'b0));
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, '0, 1'b0, 1'b0));
  endtask

  task automatic test_angle_extremes();
    send_sample(mk(0, 0, 0, 0, 0, 0, 0, M_ALL, 1'b1, 1'b0));
    send_sample(mk(32767, 0, -32768, 0, 0, 0, 0, M_ALL, 1'b1, 1'b0));
    send_sample(mk(-32768, 0, 0, 0, 0, 0, 0, M_ALL, 1'b1, 1'b0));
    send_sample(mk(0, 0, 0, 32767, 0, -32768, 0, M_ALL, 1'b1, 1'b0));
    send_sample(mk(0, 0, 0, -32768, 0, 0, 0, M_ALL, 1'b1, 1'b0));
  endtask

  task automatic test_roll_quadrants();
    int rolls [7];
    rolls = '{16384, -16384, -32768, 32767, 8192, 16383, 24576};
    foreach (rolls[i])
      send_sample(mk(2000, rolls[i], 0, 1000, 0, 0, 0, M_ALL, 1'b1, 1'b0));
  endtask

  task automatic test_pair_select();
    send_sample(mk(500, 1234, 0, 3000, -7000, 100, 200, M_ALL, 1'b1, 1'b0));
    send_sample(mk(500, 1234, 0, 3000, -7000, 100, 200,
                   M_CORE | M_TRUE | (MW'(1) << fpvr_pkg::VM_HDG_MAG), 1'b1, 1'b0));
    send_sample(mk(500, 1234, 0, 3000, -7000, 100, 200,
                   M_CORE | (MW'(1) << fpvr_pkg::VM_HDG_TRUE)
                   | (MW'(1) << fpvr_pkg::VM_TRK_MAG), 1'b1, 1'b0));
    send_sample(mk(500, 1234, 0, 3000, -7000, 100, 200, M_CORE | M_MAG, 1'b0, 1'b0));
  endtask

  task automatic test_missing_operands();
    int bits [3];
    bits = '{fpvr_pkg::VM_PITCH, fpvr_pkg::VM_ROLL, fpvr_pkg::VM_TRK_VERT};
    foreach (bits[i])
      send_sample(mk(-1500, 5000, 300, 10, 10, 2000, 2000,
                     M_ALL & ~(MW'(1) << bits[i]), 1'b1, 1'b0));
  endtask

  task automatic test_on_ground();
    send_sample(mk(-900, -3000, 100, 400, 0, -400, 0, M_ALL, 1'b1, 1'b1));
    send_sample(mk(-900, -3000, 100, 400, 0, -400, 0, M_CORE, 1'b1, 1'b1));
  endtask

  task automatic test_saturation();
    send_sample(mk(-32768, 8192, 0, -32768, 0, 0, 0, M_ALL, 1'b1, 1'b0));
    send_sample(mk(-32768, -8192, 0, -32768, 0, 0, 0, M_ALL, 1'b1, 1'b0));
  endtask

  task automatic test_random();
    repeat (RANDOM_ITEMS) send_sample(random_sample());
    in_ch.valid = 1'b0;
  endtask

  task automatic note_mismatch(string fld, logic signed [AB:0] want, logic signed [AB:0] got);
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, fld, want, got);
    n_errors++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready = 1'b0;
    end else begin
      if (stall_run == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            out_ch.ready = 1'b1;
            stall_run = $urandom_range(1, 25);
          end
          6, 7, 8: begin
            out_ch.ready = 1'b0;
            stall_run = $urandom_range(1, 6);
          end
          default: begin
            out_ch.ready = 1'b1;
            stall_run = $urandom_range(100, 300);
          end
        endcase
      end
      stall_run--;
    end
  end

  always @(posedge clk) begin
    marker_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (marker_q.size() == 0) begin
        $display("%0t: unexpected result: alpha %0d beta %0d failure %0b shown %0b", $time,
                 out_ch.fpv_alpha, out_ch.fpv_beta, out_ch.fpv_failure, out_ch.fpv_shown);
        n_errors++;
      end else begin
        e = marker_q.pop_front();
        n_checked++;
        if (out_ch.fpv_alpha !== e.alpha) note_mismatch("fpv_alpha", e.alpha, out_ch.fpv_alpha);
        if (out_ch.fpv_beta !== e.beta) note_mismatch("fpv_beta", e.beta, out_ch.fpv_beta);
        if (out_ch.fpv_failure !== e.failure)
          note_mismatch("fpv_failure", (AB+1)'(e.failure), (AB+1)'(out_ch.fpv_failure));
        if (out_ch.fpv_shown !== e.shown)
          note_mismatch("fpv_shown", (AB+1)'(e.shown), (AB+1)'(out_ch.fpv_shown));
      end
    end
  end

  initial begin
    #5000000;
    $display("timeout with %0d results outstanding", marker_q.size());
    $display("** flight_path_vector_rotation: FAILED **");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.pitch_angle = '0;
    in_ch.roll_angle = '0;
    in_ch.track_vertical_angle = '0;
    in_ch.heading_magnetic = '0;
    in_ch.heading_true = '0;
    in_ch.track_magnetic = '0;
    in_ch.track_true = '0;
    in_ch.valid_mask = '0;
    in_ch.marker_wanted = 1'b0;
    in_ch.on_ground = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_reset_hold();
    test_angle_extremes();
    test_roll_quadrants();
    test_pair_select();
    test_missing_operands();
    test_on_ground();
    test_saturation();
    test_random();

    while (marker_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 20) @(posedge clk);

    $display("%0d samples sent (%0d rotated, %0d held), %0d results checked, %0d errors",
             n_sent, n_computed, n_sent - n_computed, n_checked, n_errors);
    $display("covered wrap extremes, roll quadrants, pair selection, missing operands, ground");
    if (n_errors == 0)
      $display("** flight_path_vector_rotation: PASSED **");
    else
      $display("** flight_path_vector_rotation: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/fpvr_pkg.sv
hdl/fpvr_if.sv
hdl/fpvr_front.sv
hdl/fpvr_cell.sv
hdl/flight_path_vector_rotation.sv
hdl/fpvr_check.sv
test/tb_flight_path_vector_rotation.sv
